[design/edfs_pkg.sv]
package edfs_pkg;

  localparam logic [2:0] EV_TICK    = 3'd0;
  localparam logic [2:0] EV_END     = 3'd1;
  localparam logic [2:0] EV_MISS    = 3'd2;
  localparam logic [2:0] EV_PREEMPT = 3'd3;
  localparam logic [2:0] EV_START   = 3'd4;

  localparam int MAX_RES = 20;
  localparam int EW      = 5;

  localparam logic [2:0] REG_COST_BASE = 3'd4;

  typedef struct packed {
    logic [1:0]  task_id;
    logic [15:0] left;
    logic [31:0] dl;
    logic [31:0] rel_time;
    logic [31:0] pre_time;
  } job_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [1:0]  task_id;
    logic [15:0] left;
  } ev_t;

  typedef struct packed {
    logic begin_tick;
    logic end_step;
    logic scan_step;
    logic rel_step;
    logic sort_step;
    logic head_step;
    logic out_pop;
  } cmd_t;

  typedef struct packed {
    logic scan_done;
    logic last_task;
    logic sort_done;
    logic last_out;
  } sts_t;

  function automatic logic job_after(input job_t a, input job_t b);
    if (a.dl != b.dl) return a.dl > b.dl;
    if (a.rel_time != b.rel_time) return a.rel_time > b.rel_time;
    return a.task_id > b.task_id;
  endfunction

endpackage

[design/edfs_ctrl.sv]
module edfs_ctrl import edfs_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic tick,
  input  logic out_ready,
  input  sts_t sts,
  output cmd_t cmd,
  output logic in_ready,
  output logic out_valid
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_END  = 7'b0000010,
    S_SCAN = 7'b0000100,
    S_REL  = 7'b0001000,
    S_SORT = 7'b0010000,
    S_HEAD = 7'b0100000,
    S_EMIT = 7'b1000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid && tick) begin
          cmd.begin_tick = 1'b1;
          state_next     = S_END;
        end
      end
      S_END: begin
        cmd.end_step = 1'b1;
        state_next   = S_SCAN;
      end
      S_SCAN: begin
        if (sts.scan_done) begin
          state_next = S_REL;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_REL: begin
        cmd.rel_step = 1'b1;
        state_next   = sts.last_task ? S_SORT : S_SCAN;
      end
      S_SORT: begin
        if (sts.sort_done) begin
          state_next = S_HEAD;
        end else begin
          cmd.sort_step = 1'b1;
        end
      end
      S_HEAD: begin
        cmd.head_step = 1'b1;
        state_next    = S_EMIT;
      end
      S_EMIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          cmd.out_pop = 1'b1;
          if (sts.last_out) state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

[design/edfs_dp.sv]
module edfs_dp import edfs_pkg::*; #(
  parameter int TASKS       = 4,
  parameter int QUEUE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  output sts_t        sts,
  input  logic [15:0] period [4],
  input  logic [15:0] cost [4],
  output logic [2:0]  event_kind,
  output logic [1:0]  task_id,
  output logic [15:0] left_ticks,
  output logic [31:0] total_wait,
  output logic [31:0] jobs_made,
  output logic        dropped,
  output logic        last_event
);

  localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  job_t        q [QUEUE_DEPTH];
  ev_t         ev [MAX_RES];
  logic [15:0] cd [4];
  logic [CW-1:0] count, j, pass;
  logic [QW-1:0] pos;
  logic [1:0]  t;
  logic        running, drop;
  logic [31:0] now, ws, jobs;
  logic [EW-1:0] ev_cnt, rd;

  job_t        qj, q0, qp;
  logic        hit, ended, full, do_rel;
  logic [15:0] p, left0n;
  logic [31:0] new_dl, wfrom, wd;
  logic [32:0] wsum;
  logic [QUEUE_DEPTH-1:0] sw;
  ev_t         e0, e1, e2, tick_ev;
  logic [1:0]  nev;
  logic        add_wait;

  assign qj     = q[j[QW-1:0]];
  assign q0     = q[0];
  assign qp     = q[pos];
  assign p      = period[t];
  assign new_dl = now + {16'b0, p};
  assign hit    = (qj.task_id == t) && (qj.dl == now);
  assign ended  = running && (count != '0) && (q0.left == 16'd0);
  assign full   = (count == CW'(QUEUE_DEPTH));
  assign do_rel = (p != 16'd0) && (cd[t] == 16'd0);
  assign left0n = (q0.left != 16'd0) ? q0.left - 16'd1 : 16'd0;
  assign wfrom  = (q0.pre_time != 32'd0) ? q0.pre_time : q0.rel_time;
  assign wd     = now - wfrom;
  assign wsum   = {1'b0, ws} + {1'b0, wd};

  always_comb begin
    sw = '0;
    for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
      sw[i] = cmd.sort_step && ((i % 2) == int'(pass[0])) && ((i + 1) < int'(count))
              && job_after(q[i], q[i+1]);
    end
  end

  always_comb begin
    tick_ev = (count != '0) ? ev_t'{EV_TICK, q0.task_id, left0n}
                            : ev_t'{EV_TICK, 2'd0, 16'd0};
    e0 = tick_ev;
    e1 = tick_ev;
    e2 = tick_ev;
    nev = 2'd1;
    add_wait = 1'b0;
    if (count != '0) begin
      if (!running) begin
        e0 = '{EV_START, q0.task_id, q0.left};
        nev = 2'd2;
        add_wait = 1'b1;
      end else if (pos != '0) begin
        e0 = '{EV_PREEMPT, qp.task_id, qp.left};
        e1 = '{EV_START, q0.task_id, q0.left};
        nev = 2'd3;
        add_wait = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      running <= 1'b0;
      cd      <= '{default: 16'd0};
      now     <= '0;
      ws      <= '0;
      jobs    <= '0;
      ev_cnt  <= '0;
      drop    <= 1'b0;
      rd      <= '0;
      t       <= '0;
      j       <= '0;
      pass    <= '0;
      pos     <= '0;
    end else begin
      if (cmd.begin_tick) begin
        ev_cnt <= '0;
        drop   <= 1'b0;
        rd     <= '0;
        t      <= '0;
        j      <= '0;
        pass   <= '0;
        pos    <= '0;
      end
      if (cmd.end_step) begin
        if (ended) begin
          ev_cnt  <= EW'(1);
          count   <= count - CW'(1);
          running <= 1'b0;
        end else if (count == '0) begin
          running <= 1'b0;
        end
      end
      if (cmd.scan_step) begin
        j <= j + CW'(1);
        if (hit && (ev_cnt < EW'(MAX_RES - 3))) ev_cnt <= ev_cnt + EW'(1);
      end
      if (cmd.rel_step) begin
        t <= t + 2'd1;
        j <= '0;
        if (p == 16'd0) begin
          cd[t] <= 16'd0;
        end else if (cd[t] == 16'd0) begin
          cd[t] <= p - 16'd1;
          if (full) begin
            drop <= 1'b1;
          end else begin
            count <= count + CW'(1);
            if (jobs != '1) jobs <= jobs + 32'd1;
          end
        end else begin
          cd[t] <= cd[t] - 16'd1;
        end
      end
      if (cmd.sort_step) begin
        pass <= pass + CW'(1);
        if (sw[pos]) pos <= pos + QW'(1);
        else if (pos != '0 && sw[pos - QW'(1)]) pos <= pos - QW'(1);
      end
      if (cmd.head_step) begin
        now     <= now + 32'd1;
        ev_cnt  <= ev_cnt + EW'(nev);
        running <= running || (count != '0);
        if (add_wait) ws <= wsum[32] ? '1 : wsum[31:0];
      end
      if (cmd.out_pop) rd <= rd + EW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.end_step && ended) begin
      for (int k = 0; k < QUEUE_DEPTH - 1; k++) q[k] <= q[k+1];
      ev[0] <= '{EV_END, q0.task_id, 16'd0};
    end
    if (cmd.scan_step && hit) begin
      q[j[QW-1:0]].dl <= new_dl;
      if (ev_cnt < EW'(MAX_RES - 3)) ev[ev_cnt] <= '{EV_MISS, t, qj.left};
    end
    if (cmd.rel_step && do_rel && !full) begin
      q[count[QW-1:0]] <= '{t, cost[t], new_dl, now, 32'd0};
    end
    if (cmd.sort_step) begin
      for (int k = 1; k < QUEUE_DEPTH; k++) if (sw[k-1]) q[k] <= q[k-1];
      for (int k = 0; k < QUEUE_DEPTH - 1; k++) if (sw[k]) q[k] <= q[k+1];
    end
    if (cmd.head_step) begin
      if (count != '0) begin
        q[0].left <= left0n;
        if (running && pos != '0) q[pos].pre_time <= now;
      end
      ev[ev_cnt] <= e0;
      if (nev >= 2'd2) ev[ev_cnt + EW'(1)] <= e1;
      if (nev == 2'd3) ev[ev_cnt + EW'(2)] <= e2;
    end
  end

  assign sts.scan_done = (j >= count);
  assign sts.last_task = (t == 2'(TASKS - 1));
  assign sts.sort_done = (pass == CW'(QUEUE_DEPTH));
  assign sts.last_out  = (rd == ev_cnt - EW'(1));

  assign event_kind = ev[rd].kind;
  assign task_id    = ev[rd].task_id;
  assign left_ticks = ev[rd].left;
  assign total_wait = ws;
  assign jobs_made  = jobs;
  assign dropped    = drop;
  assign last_event = sts.last_out;

endmodule

[design/edf_periodic_task_scheduler.sv]
// Channel  | Signals                                   | Transfer
// ---------+-------------------------------------------+---------------------------
// input    | in_valid, in_ready, tick                  | in_valid & in_ready
// output   | out_valid, out_ready, event_kind..last_ev | out_valid & out_ready
// config   | psel, penable, pwrite, paddr, pwdata      | psel & penable & pwrite
//
// One tick at a time. A tick runs the end check, then for each task a miss scan over
// the queued jobs and a release step, then the odd-even sort passes and the head update,
// then one result per cycle while out_ready is high. in_ready is low from tick acceptance
// until its last result transfers. Synchronous active-high reset empties the queue.
module edf_periodic_task_scheduler import edfs_pkg::*; #(
  parameter int TASKS       = 4,
  parameter int QUEUE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        tick,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  event_kind,
  output logic [1:0]  task_id,
  output logic [15:0] left_ticks,
  output logic [31:0] total_wait,
  output logic [31:0] jobs_made,
  output logic        dropped,
  output logic        last_event,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [15:0] period [4];
  logic [15:0] cost [4];
  logic [2:0]  reg_idx;
  cmd_t        cmd;
  sts_t        sts;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      period <= '{default: 16'd0};
      cost   <= '{default: 16'd1};
    end else if (psel && penable && pwrite) begin
      if (reg_idx >= REG_COST_BASE) cost[reg_idx[1:0]] <= pwdata[15:0];
      else period[reg_idx[1:0]] <= pwdata[15:0];
    end
  end

  assign prdata = {16'd0, (reg_idx >= REG_COST_BASE) ? cost[reg_idx[1:0]]
                                                     : period[reg_idx[1:0]]};

  edfs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .tick      (tick),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd),
    .in_ready  (in_ready),
    .out_valid (out_valid)
  );

  edfs_dp #(
    .TASKS       (TASKS),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .period     (period),
    .cost       (cost),
    .event_kind (event_kind),
    .task_id    (task_id),
    .left_ticks (left_ticks),
    .total_wait (total_wait),
    .jobs_made  (jobs_made),
    .dropped    (dropped),
    .last_event (last_event)
  );

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid)) else $error("input taken while results pending");

  a_last_is_tick: assert property (@(posedge clk) disable iff (rst)
    out_valid && last_event |-> event_kind == EV_TICK) else $error("last result not tick done");

  a_tick_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_kind == EV_TICK |-> last_event) else $error("tick done not last");

endmodule
